// File: rtl/ssc_pkg.sv
// Package for the sample smoother with confidence tracking.
// Holds the request and response word types, the multiplier status type
// and the width and fixed-point constants used by the core and its serial multiplier.
package ssc_pkg;

   localparam int MUL_X_WIDTH   = 42;
   localparam int MUL_M_WIDTH   = 16;
   localparam int MUL_ACC_WIDTH = MUL_X_WIDTH + MUL_M_WIDTH;
   localparam int MUL_CNT_WIDTH = $clog2(MUL_M_WIDTH);

   localparam logic [15:0] WEIGHT_RESET = 16'd58982;
   localparam logic [15:0] WEIGHT_MAX   = 16'd62259;
   localparam logic [15:0] NOISE_KEEP   = 16'd62259;
   localparam logic [15:0] NOISE_TAKE   = 16'd3277;

   localparam logic [3:0] CONF_MAX   = 4'd12;
   localparam logic [3:0] CONF_READY = 4'd6;
   localparam logic [3:0] CONF_GAIN  = 4'd3;

   localparam logic REG_SMOOTHING_WEIGHT = 1'b0;

   typedef struct packed {
      logic               read_ok;
      logic signed [23:0] raw_sample;
   } req_word_type;

   typedef struct packed {
      logic               is_ready;
      logic signed [39:0] smoothed_value;
      logic [39:0]        noise_level;
      logic [3:0]         confidence_level;
      logic [31:0]        total_failures;
      logic [31:0]        failure_streak;
   } rsp_word_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_status_type;

endpackage

// File: rtl/ssc_serial_mul.sv
// Shift-and-add multiplier that takes one multiplier bit per cycle, MSB first.
// Signed multiplicand times unsigned multiplier; depends on ssc_pkg.
module ssc_serial_mul (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [ssc_pkg::MUL_X_WIDTH-1:0] x_in,
   input  logic [ssc_pkg::MUL_M_WIDTH-1:0]        m_in,
   output ssc_pkg::mul_status_type                status,
   output logic signed [ssc_pkg::MUL_ACC_WIDTH-1:0] product
);

   logic signed [ssc_pkg::MUL_ACC_WIDTH-1:0] acc_ff, acc_in;
   logic signed [ssc_pkg::MUL_X_WIDTH-1:0]   x_ff;
   logic [ssc_pkg::MUL_M_WIDTH-1:0]          m_ff;
   logic [ssc_pkg::MUL_CNT_WIDTH-1:0]        cnt_ff;
   logic                                     busy_ff, done_ff;

   always_comb begin
      acc_in = {acc_ff[ssc_pkg::MUL_ACC_WIDTH-2:0], 1'b0};
      if (m_ff[ssc_pkg::MUL_M_WIDTH-1]) begin
         acc_in = acc_in + {{ssc_pkg::MUL_M_WIDTH{x_ff[ssc_pkg::MUL_X_WIDTH-1]}}, x_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= ssc_pkg::MUL_CNT_WIDTH'(ssc_pkg::MUL_M_WIDTH - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
         x_ff   <= x_in;
         m_ff   <= m_in;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         m_ff   <= {m_ff[ssc_pkg::MUL_M_WIDTH-2:0], 1'b0};
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign product     = acc_ff;

endmodule

// File: rtl/sample_smoother_with_confidence_core.sv
// Sample smoother core: confidence count, failure counters, EMA filter and noise; uses
// ssc_pkg and ssc_serial_mul. One word is in work at a time, set by the control sequence.
// A failure or first good read goes from ST_IDLE to ST_DONE and shows its result when
// ST_DONE can load the response register; a filtered read first runs three serial
// products in ST_MUL_F, ST_MUL_N and ST_MUL_R. A new word is taken only in ST_IDLE.
// Synchronous active-high reset clears control and filter state; weight resets to 0.9.
module sample_smoother_with_confidence_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ssc_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ssc_pkg::rsp_word_type rsp_word,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL_F = 3'd1;
   localparam logic [2:0] ST_MUL_N = 3'd2;
   localparam logic [2:0] ST_MUL_R = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]         state_ff;
   logic [15:0]        weight_ff;
   logic [3:0]         conf_ff;
   logic               loaded_ff;
   logic signed [39:0] filter_ff;
   logic [40:0]        noise_ff;
   logic [31:0]        total_ff, run_ff;
   logic signed [39:0] sq_ff;
   logic [40:0]        res_ff, part_ff;
   logic               rsp_valid_ff;
   ssc_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic               accept, load_ok;
   logic signed [39:0] sq;
   logic [15:0]        w_clamped;
   logic [4:0]         conf_sum;
   logic signed [40:0] q;
   logic [40:0]        res_in, prod_hi;
   logic               ready;

   logic                                     mul_start;
   logic signed [ssc_pkg::MUL_X_WIDTH-1:0]   mul_x;
   logic [ssc_pkg::MUL_M_WIDTH-1:0]          mul_m;
   ssc_pkg::mul_status_type                  mul_stat;
   logic signed [ssc_pkg::MUL_ACC_WIDTH-1:0] mul_product;

   ssc_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .x_in    (mul_x),
      .m_in    (mul_m),
      .status  (mul_stat),
      .product (mul_product)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign load_ok   = !rsp_valid_ff || !rsp_stall;
   assign sq        = {req_word.raw_sample, 16'b0};
   assign w_clamped = (weight_ff > ssc_pkg::WEIGHT_MAX) ? ssc_pkg::WEIGHT_MAX : weight_ff;
   assign conf_sum  = {1'b0, conf_ff} + {1'b0, ssc_pkg::CONF_GAIN};
   assign q         = mul_product[56:16];
   assign prod_hi   = mul_product[56:16];
   assign res_in    = q[40] ? 41'(-q) : 41'(q);
   assign ready     = (conf_ff >= ssc_pkg::CONF_READY);

   always_comb begin
      mul_start = 1'b0;
      mul_x     = {{2{filter_ff[39]}}, filter_ff} - {{2{sq[39]}}, sq};
      mul_m     = w_clamped;
      case (state_ff)
         ST_IDLE: begin
            mul_start = accept && req_word.read_ok && loaded_ff;
         end
         ST_MUL_F: begin
            mul_start = mul_stat.done;
            mul_x     = {1'b0, noise_ff};
            mul_m     = ssc_pkg::NOISE_KEEP;
         end
         ST_MUL_N: begin
            mul_start = mul_stat.done;
            mul_x     = {1'b0, res_ff};
            mul_m     = ssc_pkg::NOISE_TAKE;
         end
         default: begin
            mul_start = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_word_in.is_ready         = ready;
      rsp_word_in.smoothed_value   = ready ? filter_ff : 40'sd0;
      rsp_word_in.noise_level      = ready ? noise_ff[39:0] : 40'd0;
      rsp_word_in.confidence_level = conf_ff;
      rsp_word_in.total_failures   = total_ff;
      rsp_word_in.failure_streak   = run_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         weight_ff    <= ssc_pkg::WEIGHT_RESET;
         conf_ff      <= '0;
         loaded_ff    <= 1'b0;
         filter_ff    <= '0;
         noise_ff     <= '0;
         total_ff     <= '0;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (psel && penable && pwrite && (paddr[2] == ssc_pkg::REG_SMOOTHING_WEIGHT)) begin
            weight_ff <= pwdata[15:0];
         end
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_DONE;
                  if (!req_word.read_ok) begin
                     total_ff <= total_ff + 32'd1;
                     run_ff   <= run_ff + 32'd1;
                     if (conf_ff != '0) begin
                        conf_ff <= conf_ff - 4'd1;
                     end
                  end else begin
                     run_ff  <= '0;
                     conf_ff <= (conf_sum > {1'b0, ssc_pkg::CONF_MAX}) ?
                                ssc_pkg::CONF_MAX : conf_sum[3:0];
                     if (!loaded_ff) begin
                        filter_ff <= sq;
                        noise_ff  <= '0;
                        loaded_ff <= 1'b1;
                     end else begin
                        state_ff <= ST_MUL_F;
                     end
                  end
               end
            end
            ST_MUL_F: begin
               if (mul_stat.done) begin
                  filter_ff <= sq_ff + q[39:0];
                  state_ff  <= ST_MUL_N;
               end
            end
            ST_MUL_N: begin
               if (mul_stat.done) begin
                  state_ff <= ST_MUL_R;
               end
            end
            ST_MUL_R: begin
               if (mul_stat.done) begin
                  noise_ff <= part_ff + prod_hi;
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (load_ok) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sq_ff <= sq;
      end
      if (state_ff == ST_MUL_F && mul_stat.done) begin
         res_ff <= res_in;
      end
      if (state_ff == ST_MUL_N && mul_stat.done) begin
         part_ff <= prod_hi;
      end
      if (state_ff == ST_DONE && load_ok) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign prdata    = (paddr[2] == ssc_pkg::REG_SMOOTHING_WEIGHT) ? {16'b0, weight_ff} : 32'b0;
   assign pready    = 1'b1;

   a_conf_bound: assert property (@(posedge clock) disable iff (reset)
      conf_ff <= ssc_pkg::CONF_MAX)
      else $error("confidence above its cap");

   a_mul_in_seq: assert property (@(posedge clock) disable iff (reset)
      (mul_stat.busy || mul_stat.done) |->
      (state_ff == ST_MUL_F || state_ff == ST_MUL_N || state_ff == ST_MUL_R))
      else $error("multiplier active outside the filter sequence");

   a_not_ready_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_word_ff.is_ready) |->
      (rsp_word_ff.smoothed_value == 40'sd0 && rsp_word_ff.noise_level == 40'd0))
      else $error("filter output shown while not ready");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("accepted word did not start processing");

endmodule

// File: test/sample_smoother_with_confidence_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for sample_smoother_with_confidence_core: a directed table and
// random read outcomes under random stalls, checked against an internal predictor.
// Depends on ssc_pkg and the core RTL only.
module sample_smoother_with_confidence_core_tb;

   typedef struct {
      ssc_pkg::req_word_type word;
      bit                    typed;
      ssc_pkg::rsp_word_type want;
   } step_row_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   ssc_pkg::req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   ssc_pkg::rsp_word_type rsp_word;
   logic         psel;
   logic         penable;
   logic         pwrite;
   logic [2:0]   paddr;
   logic [31:0]  pwdata;
   logic [31:0]  prdata;
   logic         pready;

   logic [15:0]  weight_model;
   logic [3:0]   confidence_model;
   logic         loaded_model;
   longint       filter_model;
   longint       noise_model;
   logic [31:0]  failure_total_model;
   logic [31:0]  failure_run_model;

   ssc_pkg::rsp_word_type expected_readings[$];
   step_row_type directed_rows[$];
   int unsigned  mismatch_count = 0;
   int unsigned  hold_cycles = 0;
   int unsigned  ok_percent = 80;
   bit           no_idle = 1'b0;

   sample_smoother_with_confidence_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   function automatic ssc_pkg::rsp_word_type advance_smoother(ssc_pkg::req_word_type w);
      ssc_pkg::rsp_word_type r;
      longint raw;
      longint wt;
      longint diff;
      longint resid;
      raw = {{40{w.raw_sample[23]}}, w.raw_sample};
      if (!w.read_ok) begin
         failure_total_model = failure_total_model + 32'd1;
         failure_run_model = failure_run_model + 32'd1;
         if (confidence_model != 4'd0) begin
            confidence_model = confidence_model - 4'd1;
         end
      end else begin
         failure_run_model = 32'd0;
         confidence_model = (confidence_model > ssc_pkg::CONF_MAX - ssc_pkg::CONF_GAIN) ?
                            ssc_pkg::CONF_MAX : confidence_model + ssc_pkg::CONF_GAIN;
         if (!loaded_model) begin
            filter_model = raw * 65536;
            noise_model = 0;
            loaded_model = 1'b1;
         end else begin
            wt = (weight_model > ssc_pkg::WEIGHT_MAX) ? ssc_pkg::WEIGHT_MAX : weight_model;
            filter_model = ((filter_model * wt) >>> 16) + raw * (65536 - wt);
            diff = raw * 65536 - filter_model;
            resid = (diff < 0) ? -diff : diff;
            noise_model = ((noise_model * longint'(ssc_pkg::NOISE_KEEP)) >>> 16) +
                          ((resid * longint'(ssc_pkg::NOISE_TAKE)) >>> 16);
         end
      end
      r.is_ready = (confidence_model >= ssc_pkg::CONF_READY);
      r.smoothed_value = r.is_ready ? filter_model[39:0] : 40'd0;
      r.noise_level = r.is_ready ? noise_model[39:0] : 40'd0;
      r.confidence_level = confidence_model;
      r.total_failures = failure_total_model;
      r.failure_streak = failure_run_model;
      return r;
   endfunction

   function automatic void add_row(bit ok, logic [23:0] sample, bit typed = 1'b0,
                                   logic [3:0] conf = 4'd0, logic [31:0] total = 32'd0,
                                   logic [31:0] streak = 32'd0);
      step_row_type row;
      row.word.read_ok = ok;
      row.word.raw_sample = sample;
      row.typed = typed;
      row.want = '0;
      row.want.confidence_level = conf;
      row.want.total_failures = total;
      row.want.failure_streak = streak;
      directed_rows.push_back(row);
   endfunction

   function automatic int unsigned draw_gap();
      if (no_idle || $urandom_range(0, 3) == 0) begin
         return 0;
      end
      return $urandom_range(0, 18);
   endfunction

   function automatic ssc_pkg::req_word_type random_read();
      ssc_pkg::req_word_type w;
      w.read_ok = ($urandom_range(0, 99) < ok_percent);
      case ($urandom_range(0, 7))
         0: begin
            w.raw_sample = 24'h7FFFFF;
         end
         1: begin
            w.raw_sample = 24'h800000;
         end
         2: begin
            w.raw_sample = 24'($urandom_range(0, 511)) - 24'd256;
         end
         default: begin
            w.raw_sample = 24'($urandom);
         end
      endcase
      return w;
   endfunction

   task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("Mismatch on %s: expected %h, got %h", name, want, got);
         end
      end
   endtask

   task automatic offer_read(ssc_pkg::req_word_type w, bit typed,
                             ssc_pkg::rsp_word_type want);
      int unsigned gap;
      ssc_pkg::rsp_word_type predicted;
      gap = draw_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = advance_smoother(w);
      expected_readings.push_back(typed ? want : predicted);
   endtask

   task automatic drain_pipeline();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
   endtask

   task automatic set_weight(logic [15:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {ssc_pkg::REG_SMOOTHING_WEIGHT, 2'b00};
      pwdata <= {16'd0, value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      weight_model = value;
      @(negedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      compare_field("weight readback", {16'd0, value}, prdata);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   always @(posedge clock) begin
      ssc_pkg::rsp_word_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_readings.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("Unexpected result word %h", rsp_word);
            end
         end else begin
            want = expected_readings.pop_front();
            compare_field("is_ready", want.is_ready, rsp_word.is_ready);
            compare_field("smoothed_value", want.smoothed_value, rsp_word.smoothed_value);
            compare_field("noise_level", want.noise_level, rsp_word.noise_level);
            compare_field("confidence_level", want.confidence_level,
                          rsp_word.confidence_level);
            compare_field("total_failures", want.total_failures, rsp_word.total_failures);
            compare_field("failure_streak", want.failure_streak, rsp_word.failure_streak);
         end
      end
   end

   always begin : result_drain
      int unsigned stall_cycles;
      if (hold_cycles != 0) begin
         stall_cycles = hold_cycles;
         hold_cycles = 0;
      end else begin
         stall_cycles = draw_gap();
      end
      if (stall_cycles != 0) begin
         @(negedge clock);
         rsp_stall <= 1'b1;
         repeat (stall_cycles - 1) @(negedge clock);
      end
      @(negedge clock);
      rsp_stall <= 1'b0;
      do @(posedge clock); while (!(rsp_valid === 1'b1 && reset === 1'b0));
   end

   initial begin
      #5ms;
      $display("** sample_smoother_with_confidence_core: FAILED **");
      $finish;
   end

   initial begin
      logic [15:0] phase_weights[8];
      int unsigned phase_ok[8];
      ssc_pkg::rsp_word_type unused;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      rsp_stall = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      unused = '0;
      weight_model = ssc_pkg::WEIGHT_RESET;
      confidence_model = 4'd0;
      loaded_model = 1'b0;
      filter_model = 0;
      noise_model = 0;
      failure_total_model = 32'd0;
      failure_run_model = 32'd0;
      phase_weights = '{16'd0, 16'hFFFF, ssc_pkg::WEIGHT_MAX, ssc_pkg::WEIGHT_MAX + 16'd1,
                        16'd1, 16'h8000, 16'($urandom), 16'($urandom)};
      phase_ok = '{85, 70, 95, 50, 85, 80, 90, 75};

      // Failures before any good read, then the first good read loads the filter.
      add_row(1'b0, 24'h7FFFFF, 1'b1, 4'd0, 32'd1, 32'd1);
      add_row(1'b0, 24'h800000, 1'b1, 4'd0, 32'd2, 32'd2);
      add_row(1'b1, 24'h7FFFFF, 1'b1, 4'd3, 32'd2, 32'd0);
      add_row(1'b1, 24'h800000);
      add_row(1'b1, 24'h000000);
      add_row(1'b1, 24'h7FFFFF);
      add_row(1'b1, 24'h800000);
      // A run of failures walks confidence from the cap down to zero and holds it there.
      add_row(1'b0, 24'h123456);
      repeat (5) add_row(1'b0, 24'hFFFFFF);
      add_row(1'b0, 24'h000000, 1'b1, 4'd5, 32'd9, 32'd7);
      repeat (5) add_row(1'b0, 24'hAAAAAA);
      add_row(1'b0, 24'h555555, 1'b1, 4'd0, 32'd15, 32'd13);
      add_row(1'b1, 24'h000001, 1'b1, 4'd3, 32'd15, 32'd0);
      add_row(1'b1, 24'hFFFFFF);
      add_row(1'b1, 24'h400000);
      add_row(1'b1, 24'hC00000);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         offer_read(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
      end

      for (int p = 0; p < 8; p++) begin
         drain_pipeline();
         set_weight(phase_weights[p]);
         ok_percent = phase_ok[p];
         no_idle = (p == 5);
         if (p == 3) begin
            hold_cycles = 300;
         end
         repeat (130) offer_read(random_read(), 1'b0, unused);
      end

      drain_pipeline();
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && expected_readings.size() == 0) begin
         $display("** sample_smoother_with_confidence_core: PASSED **");
      end else begin
         $display("** sample_smoother_with_confidence_core: FAILED **");
      end
      $finish;
   end
endmodule
